[rtl/jsfe_pkg.sv]
package jsfe_pkg;

	// Longest key the match window supports.
	localparam int KEY_BYTES = 8;

	localparam int CFG_DATA_W = 64;
	localparam int CFG_INDEX_W = 2;

	localparam logic [CFG_INDEX_W-1:0] REG_KEY_TEXT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_KEY_LENGTH = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_OUT_CAPACITY = 2'd2;

	localparam logic [8:0] OUT_CAPACITY_RESET = 9'd16;

	localparam logic [1:0] KIND_VALUE = 2'd0;
	localparam logic [1:0] KIND_OK = 2'd1;
	localparam logic [1:0] KIND_FAIL = 2'd2;

	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_DEL = 8'h7F;

	typedef struct packed {
		logic shift;
		logic clear;
	} win_ctrl_t;

endpackage

[rtl/jsfe_window.sv]
module jsfe_window #(
	parameter int KEY_BYTES = jsfe_pkg::KEY_BYTES
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  jsfe_pkg::win_ctrl_t    ctrl,
	input  logic [7:0]             in_byte,
	input  logic [8*KEY_BYTES-1:0] key_text,
	input  logic [3:0]             key_length,
	output logic                   match
);

	localparam int WIN_DEPTH = KEY_BYTES + 2;
	localparam int SEEN_W = $clog2(WIN_DEPTH + 1);
	localparam int KLEN_W = $clog2(KEY_BYTES + 1);

	// Only the newest KEY_BYTES+1 stored bytes can ever take part in a compare.
	logic [7:0]        recent_q [KEY_BYTES+1];
	logic [SEEN_W-1:0] seen_q;
	logic [SEEN_W-1:0] seen_next;
	logic [7:0]        win [KEY_BYTES+2];
	logic [KLEN_W-1:0] klen;
	logic              match_k [KEY_BYTES+1];

	assign seen_next = (seen_q == SEEN_W'(WIN_DEPTH)) ? seen_q : seen_q + 1'b1;
	assign klen = (key_length > 4'(KEY_BYTES)) ? KLEN_W'(KEY_BYTES) : KLEN_W'(key_length);

	always_comb begin
		win[0] = in_byte;
		for (int j = 1; j < KEY_BYTES + 2; j++) begin
			win[j] = recent_q[j-1];
		end
	end

	// One candidate compare per possible key length; the configured length picks one.
	always_comb begin
		for (int k = 0; k <= KEY_BYTES; k++) begin
			match_k[k] = (seen_next >= SEEN_W'(k + 2)) && (win[0] == jsfe_pkg::CH_QUOTE)
				&& (win[k+1] == jsfe_pkg::CH_QUOTE);
			for (int i = 0; i < k; i++) begin
				match_k[k] = match_k[k] && (win[k-i] == key_text[8*i +: 8]);
			end
		end
	end

	assign match = match_k[klen];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q <= '0;
		end else if (ctrl.clear) begin
			seen_q <= '0;
		end else if (ctrl.shift) begin
			seen_q <= seen_next;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.shift) begin
			recent_q[0] <= in_byte;
			for (int j = 1; j < KEY_BYTES + 1; j++) begin
				recent_q[j] <= recent_q[j-1];
			end
		end
	end

endmodule

[rtl/json_string_field_extractor_top.sv]
// Pulls the string value of one configured key out of a byte-wide document stream.
// Configuration: write key_text (index 0), key_length (index 1) and out_capacity
// (index 2) through cfg_valid/cfg_ready/cfg_index/cfg_data while the block is idle.
// cfg_ready is always high.
// Input channel: one document byte per beat on in_byte; a beat with end_of_doc set
// closes the document and starts the next one.
// Output channel: each beat carries result_kind (value byte, success or failure),
// value_byte and the running value_count. An input beat gives at most one output beat.
// Throughput is one byte per cycle while the receiver does not stall. A byte is
// registered in the input register when accepted and decoded into the output
// register once that register is free to take it.
// When the receiver stalls a valid beat, the output register holds it; an empty input
// register can still take one byte, then in_stall stays high until the output moves.
// Reset clears the key registers, sets out_capacity to 16 and returns the scanner
// to the key search with empty output and input registers.
module json_string_field_extractor_top #(
	parameter int KEY_BYTES = jsfe_pkg::KEY_BYTES
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [7:0]                        in_byte,
	input  logic                              end_of_doc,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [1:0]                        result_kind,
	output logic [7:0]                        value_byte,
	output logic [7:0]                        value_count,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [jsfe_pkg::CFG_INDEX_W-1:0]  cfg_index,
	input  logic [jsfe_pkg::CFG_DATA_W-1:0]   cfg_data
);

	typedef enum logic [5:0] {
		PH_SEARCH = 6'b000001,
		PH_SKIP   = 6'b000010,
		PH_VALUE  = 6'b000100,
		PH_ESC    = 6'b001000,
		PH_HEX    = 6'b010000,
		PH_DONE   = 6'b100000
	} phase_t;

	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_U = 8'h75;
	localparam logic [7:0] CH_N = 8'h6E;
	localparam logic [7:0] CH_T = 8'h74;

	function automatic logic [7:0] clean_byte(input logic [7:0] b);
		clean_byte = (b < jsfe_pkg::CH_SPACE || b == jsfe_pkg::CH_DEL) ? jsfe_pkg::CH_SPACE : b;
	endfunction

	function automatic logic is_hex(input logic [7:0] b);
		is_hex = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66)
			|| (b >= 8'h41 && b <= 8'h46);
	endfunction

	logic [8*KEY_BYTES-1:0] key_text_q;
	logic [3:0]             key_length_q;
	logic [8:0]             capacity_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       eod_s1;

	phase_t     phase_q, phase_next;
	logic [7:0] emitted_q, emitted_next;
	logic [1:0] hex_q, hex_next;

	logic       out_valid_q;
	logic [1:0] kind_q;
	logic [7:0] vbyte_q;
	logic [7:0] count_q;

	logic       out_free;
	logic       fire;
	logic       accept;
	logic       match;
	logic       emit_req;
	logic [7:0] emit_byte;
	logic       can_emit;
	logic       res_valid;
	logic [1:0] res_kind;
	logic [7:0] res_byte;
	logic [7:0] res_count;

	jsfe_pkg::win_ctrl_t win_ctrl;

	assign out_free = !out_valid_q || !out_stall;
	assign fire = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign accept = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	assign win_ctrl.shift = fire && !eod_s1 && (phase_q == PH_SEARCH);
	assign win_ctrl.clear = fire && eod_s1;

	jsfe_window #(
		.KEY_BYTES(KEY_BYTES)
	) u_window (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (win_ctrl),
		.in_byte    (byte_s1),
		.key_text   (key_text_q),
		.key_length (key_length_q),
		.match      (match)
	);

	// The emit limit is both the buffer capacity and the 8-bit count.
	assign can_emit = (({1'b0, emitted_q} + 9'd1) < capacity_q) && (emitted_q != 8'hFF);

	always_comb begin
		phase_next = phase_q;
		emitted_next = emitted_q;
		hex_next = hex_q;
		emit_req = 1'b0;
		emit_byte = jsfe_pkg::CH_SPACE;
		res_valid = 1'b0;
		res_kind = jsfe_pkg::KIND_FAIL;
		res_byte = 8'h00;
		res_count = emitted_q;
		if (eod_s1) begin
			res_valid = (phase_q != PH_DONE);
			phase_next = PH_SEARCH;
			emitted_next = '0;
			hex_next = '0;
		end else begin
			case (phase_q)
				PH_SEARCH: begin
					if (match) begin
						phase_next = PH_SKIP;
					end
				end
				PH_SKIP: begin
					if (byte_s1 == jsfe_pkg::CH_QUOTE) begin
						phase_next = PH_VALUE;
					end else if (byte_s1 != jsfe_pkg::CH_SPACE && byte_s1 != CH_TAB
						&& byte_s1 != CH_COLON) begin
						res_valid = 1'b1;
						phase_next = PH_DONE;
					end
				end
				PH_VALUE: begin
					if (byte_s1 == jsfe_pkg::CH_QUOTE) begin
						res_valid = 1'b1;
						res_kind = jsfe_pkg::KIND_OK;
						phase_next = PH_DONE;
					end else if (byte_s1 == CH_BSLASH) begin
						phase_next = PH_ESC;
					end else begin
						emit_req = 1'b1;
						emit_byte = clean_byte(byte_s1);
					end
				end
				PH_ESC: begin
					if (byte_s1 == CH_U) begin
						hex_next = '0;
						phase_next = PH_HEX;
					end else begin
						phase_next = PH_VALUE;
						emit_req = 1'b1;
						emit_byte = (byte_s1 == CH_N || byte_s1 == CH_T) ? jsfe_pkg::CH_SPACE
							: clean_byte(byte_s1);
					end
				end
				PH_HEX: begin
					if (!is_hex(byte_s1)) begin
						res_valid = 1'b1;
						phase_next = PH_DONE;
					end else if (hex_q == 2'd3) begin
						// The fourth digit completes the escape, which stands as one space.
						hex_next = '0;
						phase_next = PH_VALUE;
						emit_req = 1'b1;
					end else begin
						hex_next = hex_q + 2'd1;
					end
				end
				PH_DONE: begin
				end
				default: begin
					phase_next = PH_DONE;
				end
			endcase
			if (emit_req && can_emit) begin
				emitted_next = emitted_q + 8'd1;
				res_valid = 1'b1;
				res_kind = jsfe_pkg::KIND_VALUE;
				res_byte = emit_byte;
				res_count = emitted_q + 8'd1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_text_q <= '0;
			key_length_q <= '0;
			capacity_q <= jsfe_pkg::OUT_CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				jsfe_pkg::REG_KEY_TEXT: key_text_q <= cfg_data[8*KEY_BYTES-1:0];
				jsfe_pkg::REG_KEY_LENGTH: key_length_q <= cfg_data[3:0];
				jsfe_pkg::REG_OUT_CAPACITY: capacity_q <= cfg_data[8:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
			eod_s1 <= end_of_doc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_SEARCH;
			emitted_q <= '0;
			hex_q <= '0;
		end else if (fire) begin
			phase_q <= phase_next;
			emitted_q <= emitted_next;
			hex_q <= hex_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && res_valid) begin
			kind_q <= res_kind;
			vbyte_q <= res_byte;
			count_q <= res_count;
		end
	end

	assign out_valid = out_valid_q;
	assign result_kind = kind_q;
	assign value_byte = vbyte_q;
	assign value_count = count_q;

endmodule

[rtl/jsfe_checker.sv]
module jsfe_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       out_valid,
	input logic       out_stall,
	input logic [1:0] result_kind,
	input logic [7:0] value_byte,
	input logic [7:0] value_count
);

	// A value beat always counts itself.
	a_value_counted: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == jsfe_pkg::KIND_VALUE |-> value_count != 8'd0)
		else $error("value beat with zero count");

	// Decoded bytes are sanitized: no control bytes and no DEL.
	a_value_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind == jsfe_pkg::KIND_VALUE
		|-> value_byte >= jsfe_pkg::CH_SPACE && value_byte != jsfe_pkg::CH_DEL)
		else $error("unsanitized value byte");

	// Completion beats carry a zero byte and a known kind.
	a_done_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_kind != jsfe_pkg::KIND_VALUE
		|-> value_byte == 8'h00
			&& (result_kind == jsfe_pkg::KIND_OK || result_kind == jsfe_pkg::KIND_FAIL))
		else $error("malformed completion beat");

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(result_kind)
			&& $stable(value_byte) && $stable(value_count))
		else $error("stalled output beat changed");

endmodule

bind json_string_field_extractor_top jsfe_checker u_jsfe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.result_kind (result_kind),
	.value_byte  (value_byte),
	.value_count (value_count)
);
